// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RTL files of the neighbor generator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/phsn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsn_pkg
// Types, constants and the offset table of the half-shell neighbor generator.
// ----------------------------------------------------------------------------
package phsn_pkg;

  localparam int unsigned MaxDim        = 16;
  localparam int unsigned ListSlots     = 13;
  localparam int unsigned SamePlaneBase = 4;
  localparam int unsigned StoreDepth    = 4096;
  localparam int unsigned AddrW         = $clog2(StoreDepth);
  localparam int unsigned OqDepth       = 4;
  localparam int unsigned OqCntW        = $clog2(OqDepth + 1);

  typedef enum logic [1:0] {
    CfgGridX = 2'd0,
    CfgGridY = 2'd1,
    CfgGridZ = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StepKeep = 2'd0,
    StepInc  = 2'd1,
    StepDec  = 2'd2
  } step_e;

  typedef struct packed {
    step_e dx;
    step_e dy;
    step_e dz;
  } offs_t;

  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
  } coord_t;

  typedef struct packed {
    logic [4:0] nx;
    logic [4:0] ny;
    logic [4:0] nz;
  } dims_t;

  typedef struct packed {
    logic [3:0]       list_slot;
    logic [AddrW-1:0] neighbor_cell;
    logic [3:0]       reverse_slot;
    logic             reverse_overflow;
    logic             last;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic issue;
  } back_sts_t;

  // Forward half-shell offsets in emission order
  localparam offs_t NbrOffs [ListSlots] = '{
    '{StepInc,  StepKeep, StepKeep},
    '{StepInc,  StepInc,  StepKeep},
    '{StepInc,  StepInc,  StepInc },
    '{StepInc,  StepKeep, StepInc },
    '{StepKeep, StepInc,  StepKeep},
    '{StepDec,  StepInc,  StepKeep},
    '{StepDec,  StepInc,  StepInc },
    '{StepKeep, StepInc,  StepInc },
    '{StepKeep, StepKeep, StepInc },
    '{StepDec,  StepKeep, StepInc },
    '{StepDec,  StepDec,  StepInc },
    '{StepKeep, StepDec,  StepInc },
    '{StepInc,  StepDec,  StepInc }
  };

endpackage

// ===== hdl/phsn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsn_front
// Accepts cell requests, clamps the coordinates into the grid and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module phsn_front import phsn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push,
  output logic   full,
  input  logic [3:0] cell_x_i,
  input  logic [3:0] cell_y_i,
  input  logic [3:0] cell_z_i,
  input  dims_t  dims_i,
  input  logic   block_i,
  output logic   q_valid_o,
  output coord_t q_data_o,
  input  logic   q_pop_i
);

  localparam int unsigned FqDepth = 2;
  localparam int unsigned FqPtrW  = $clog2(FqDepth);
  localparam int unsigned FqCntW  = $clog2(FqDepth + 1);

  coord_t              fq_mem [FqDepth];
  logic [FqPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FqPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FqCntW-1:0]   cnt_q, cnt_d;
  logic                accept;
  coord_t              clamped;

  // Clamp a coordinate to the last cell when it lies outside the grid
  function automatic logic [3:0] clamp_coord(logic [3:0] c, logic [4:0] n);
    logic [4:0] top;
    top = n - 5'd1;
    return ({1'b0, c} >= n) ? top[3:0] : c;
  endfunction

  assign full   = (cnt_q == FqCntW'(FqDepth)) || block_i;
  assign accept = push && !full;

  always_comb begin
    clamped.x = clamp_coord(cell_x_i, dims_i.nx);
    clamped.y = clamp_coord(cell_y_i, dims_i.ny);
    clamped.z = clamp_coord(cell_z_i, dims_i.nz);
  end

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) begin
      wr_ptr_d = wr_ptr_q + FqPtrW'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + FqPtrW'(1);
    end
    if (accept && !q_pop_i) begin
      cnt_d = cnt_q + FqCntW'(1);
    end else if (!accept && q_pop_i) begin
      cnt_d = cnt_q - FqCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the clamped request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fq_mem[wr_ptr_q] <= clamped;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = fq_mem[rd_ptr_q];

endmodule

// ===== hdl/phsn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsn_back
// Walks the 13 half-shell offsets of one cell, one per cycle while the result
// queue has room, and does the read-modify-write of the neighbor's reverse counter in a 4096-entry memory.
// ----------------------------------------------------------------------------
module phsn_back import phsn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dims_t             dims_i,
  input  logic              q_valid_i,
  input  coord_t            q_data_i,
  output logic              q_pop_o,
  input  logic [OqCntW-1:0] oq_cnt_i,
  output logic              res_valid_o,
  output res_t              res_o,
  output back_sts_t         sts_o
);

  localparam int unsigned KW = $clog2(ListSlots);

  // Sequencer state
  logic             busy_q, busy_d;
  logic [KW-1:0]    k_q, k_d;
  logic [3:0]       same_q, same_d;
  logic [3:0]       oth_q, oth_d;
  coord_t           cell_q;
  logic [8:0]       stride_q;

  // Clear pass state
  logic             clearing_q;
  logic [AddrW-1:0] clr_q;

  // Counter memory
  logic [3:0]       cnt_mem [StoreDepth];
  logic [3:0]       rd_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [3:0]       mem_wd;

  // Second stage
  logic             b_vld_q;
  logic [AddrW-1:0] b_addr_q;
  logic [3:0]       b_slot_q;
  logic             b_last_q;
  logic             b_fwd_q;
  logic [3:0]       b_fwd_val_q;

  logic             issue, is_last, ld, room;
  offs_t            offs;
  logic [3:0]       ax, ay, az;
  logic [8:0]       py;
  logic [12:0]      pz, lin_full;
  logic [AddrW-1:0] lin;
  logic             same_plane;
  logic [3:0]       slot;
  logic [3:0]       cnt_now, cnt_next, rslot;
  logic             ovf;

  // Step a coordinate by one cell with wrap-around
  function automatic logic [3:0] wrap_step(logic [3:0] c, step_e d, logic [4:0] n);
    logic [4:0] top;
    logic [3:0] r;
    top = n - 5'd1;
    r   = c;
    case (d)
      StepInc: r = ({1'b0, c} == top) ? 4'd0 : c + 4'd1;
      StepDec: r = (c == 4'd0) ? top[3:0] : c - 4'd1;
      default: r = c;
    endcase
    return r;
  endfunction

  // Issue only when the result queue has a free place for it
  assign room    = (oq_cnt_i + OqCntW'(b_vld_q)) < OqCntW'(OqDepth);
  assign issue   = busy_q && room;
  assign is_last = (k_q == KW'(ListSlots - 1));
  assign ld      = q_valid_i && !clearing_q && (!busy_q || (issue && is_last));
  assign q_pop_o = ld;

  // Neighbor address for the current offset
  always_comb begin
    offs       = NbrOffs[k_q];
    ax         = wrap_step(cell_q.x, offs.dx, dims_i.nx);
    ay         = wrap_step(cell_q.y, offs.dy, dims_i.ny);
    az         = wrap_step(cell_q.z, offs.dz, dims_i.nz);
    py         = 9'(ay) * 9'(dims_i.nx);
    pz         = 13'(az) * 13'(stride_q);
    lin_full   = 13'(ax) + 13'(py) + pz;
    lin        = lin_full[AddrW-1:0];
    same_plane = (az == cell_q.z);
    slot       = same_plane ? same_q : oth_q;
  end

  // Advance through the offsets and load the next cell
  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    same_d = same_q;
    oth_d  = oth_q;
    if (issue) begin
      k_d = k_q + KW'(1);
      if (same_plane) begin
        same_d = same_q + 4'd1;
      end else begin
        oth_d = oth_q + 4'd1;
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (ld) begin
      busy_d = 1'b1;
      k_d    = '0;
      same_d = '0;
      oth_d  = 4'(SamePlaneBase);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      k_q        <= '0;
      same_q     <= '0;
      oth_q      <= '0;
      clearing_q <= 1'b1;
      clr_q      <= '0;
      b_vld_q    <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      k_q     <= k_d;
      same_q  <= same_d;
      oth_q   <= oth_d;
      b_vld_q <= issue;
      if (clearing_q) begin
        clr_q <= clr_q + AddrW'(1);
        if (clr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
    end
  end

  // Hold the cell, the plane stride and the second-stage payload
  always_ff @(posedge clk_i) begin
    stride_q <= 9'(dims_i.nx) * 9'(dims_i.ny);
    if (ld) begin
      cell_q <= q_data_i;
    end
    if (issue) begin
      b_addr_q    <= lin;
      b_slot_q    <= slot;
      b_last_q    <= is_last;
      b_fwd_q     <= b_vld_q && (b_addr_q == lin);
      b_fwd_val_q <= cnt_next;
    end
  end

  // Saturating counter update; take the value in flight on a repeated address
  always_comb begin
    cnt_now  = b_fwd_q ? b_fwd_val_q : rd_q;
    ovf      = (cnt_now >= 4'(ListSlots));
    cnt_next = ovf ? cnt_now : cnt_now + 4'd1;
    rslot    = ovf ? 4'(ListSlots - 1) : cnt_now;
  end

  assign mem_we = clearing_q || (b_vld_q && !ovf);
  assign mem_wa = clearing_q ? clr_q : b_addr_q;
  assign mem_wd = clearing_q ? 4'd0 : cnt_next;

  // Counter memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= cnt_mem[lin];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
  end

  assign res_valid_o            = b_vld_q;
  assign res_o.list_slot        = b_slot_q;
  assign res_o.neighbor_cell    = b_addr_q;
  assign res_o.reverse_slot     = rslot;
  assign res_o.reverse_overflow = ovf;
  assign res_o.last             = b_last_q;

  assign sts_o.clearing = clearing_q;
  assign sts_o.issue    = issue;

endmodule

// ===== hdl/phsn_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phsn_outq
// Result queue that decouples the back end from the consumer.
// ----------------------------------------------------------------------------
module phsn_outq import phsn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  res_t              data_i,
  input  logic              pop,
  output logic              empty,
  output res_t              data_o,
  output logic [OqCntW-1:0] cnt_o
);

  localparam int unsigned OqPtrW = $clog2(OqDepth);

  res_t              oq_mem [OqDepth];
  logic [OqPtrW-1:0] wr_ptr_q;
  logic [OqPtrW-1:0] rd_ptr_q;
  logic [OqCntW-1:0] cnt_q, cnt_d;
  logic              take;

  assign empty = (cnt_q == '0);
  assign take  = pop && !empty;

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !take) begin
      cnt_d = cnt_q + OqCntW'(1);
    end else if (!push_i && take) begin
      cnt_d = cnt_q - OqCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OqPtrW'(1);
      end
      if (take) begin
        rd_ptr_q <= rd_ptr_q + OqPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      oq_mem[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = oq_mem[rd_ptr_q];
  assign cnt_o  = cnt_q;

endmodule

// ===== hdl/periodic_half_shell_cell_neighbors.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_half_shell_cell_neighbors
// Emits the 13 forward half-shell neighbors of a cell on a periodic 3-D grid,
// each with its list slot and a reverse slot from a per-cell counter.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  request  | push / full               | cell_x_i, cell_y_i, cell_z_i
//  result   | empty / pop               | list_slot_o, neighbor_cell_o,
//           |                           | reverse_slot_o, reverse_overflow_o,
//           |                           | last_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A request yields 13 results, one per cycle while the result queue has room.
//  An accepted request passes through the request queue, the cell register
//  and the second stage before it reaches the result queue.
//  After reset a clear pass zeroes the 4096 counters; full is high during
//  it. Config writes are always taken (cfg_ready_o is high).
//  A stalled result queue holds back the walk without losing any result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_half_shell_cell_neighbors import phsn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  cell_x_i,
  input  logic [3:0]  cell_y_i,
  input  logic [3:0]  cell_z_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  list_slot_o,
  output logic [11:0] neighbor_cell_o,
  output logic [3:0]  reverse_slot_o,
  output logic        reverse_overflow_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  logic [4:0]        grid_x_q, grid_y_q, grid_z_q;
  dims_t             dims;
  logic              fq_valid, fq_pop;
  coord_t            fq_data;
  logic              res_valid;
  res_t              res, oq_data;
  logic [OqCntW-1:0] oq_cnt;
  back_sts_t         back_sts;

  // Map a register value to a usable grid size
  function automatic logic [4:0] eff_dim(logic [4:0] g);
    logic [4:0] r;
    r = g;
    if (g == 5'd0) begin
      r = 5'd1;
    end else if (g > 5'(MaxDim)) begin
      r = 5'(MaxDim);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  // Hold the grid size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= 5'd1;
      grid_y_q <= 5'd1;
      grid_z_q <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGridX: grid_x_q <= cfg_data_i;
        CfgGridY: grid_y_q <= cfg_data_i;
        CfgGridZ: grid_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.nx = eff_dim(grid_x_q);
    dims.ny = eff_dim(grid_y_q);
    dims.nz = eff_dim(grid_z_q);
  end

  phsn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .cell_x_i  (cell_x_i),
    .cell_y_i  (cell_y_i),
    .cell_z_i  (cell_z_i),
    .dims_i    (dims),
    .block_i   (back_sts.clearing),
    .q_valid_o (fq_valid),
    .q_data_o  (fq_data),
    .q_pop_i   (fq_pop)
  );

  phsn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .q_valid_i   (fq_valid),
    .q_data_i    (fq_data),
    .q_pop_o     (fq_pop),
    .oq_cnt_i    (oq_cnt),
    .res_valid_o (res_valid),
    .res_o       (res),
    .sts_o       (back_sts)
  );

  phsn_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .pop    (pop),
    .empty  (empty),
    .data_o (oq_data),
    .cnt_o  (oq_cnt)
  );

  assign list_slot_o        = oq_data.list_slot;
  assign neighbor_cell_o    = oq_data.neighbor_cell;
  assign reverse_slot_o     = oq_data.reverse_slot;
  assign reverse_overflow_o = oq_data.reverse_overflow;
  assign last_o             = oq_data.last;

  // Requests stay blocked while the counters are being cleared
  `ASSERT_CLK(a_clear_blocks_req, clk_i, rst_ni, back_sts.clearing |-> full, "request taken during clear")
  // A result never arrives at a full result queue
  `ASSERT_NEVER(a_oq_no_overrun, clk_i, rst_ni, res_valid && (oq_cnt == OqCntW'(OqDepth)), "result queue overrun")
  // Every issued neighbor is pushed into the result queue in the next cycle
  `ASSERT_CLK(a_issue_lands, clk_i, rst_ni, back_sts.issue |=> res_valid, "issued neighbor lost")

endmodule
